[rtl/ems_pkg.sv]
// Shared types, constants and the window match function of the emoji modifier stripper.
// Used by ems_front, ems_queue, ems_back and utf8_emoji_modifier_stripper.
package ems_pkg;

  localparam int WIN_MAX   = 5;  // longest proper prefix that can wait in the window
  localparam int JOB_BYTES = 6;  // window plus the new byte

  // Modifier patterns, entry 0 is the lead byte.
  localparam logic [2:0][7:0] SEL_PAT  = {8'h8F, 8'hB8, 8'hEF};
  localparam logic [4:0][7:0] ZWJ_PAT  = {8'h99, 8'hE2, 8'h8D, 8'h80, 8'hE2};
  localparam logic [2:0][7:0] SKIN_PAT = {8'h8F, 8'h9F, 8'hF0};
  localparam logic [7:0] ZWJ_FEMALE = 8'h80;
  localparam logic [7:0] ZWJ_MALE   = 8'h82;
  localparam logic [7:0] SKIN_LO    = 8'hBB;
  localparam logic [7:0] SKIN_HI    = 8'hBF;

  localparam logic [2:0] SEL_LEN  = 3'd3;
  localparam logic [2:0] ZWJ_LEN  = 3'd6;
  localparam logic [2:0] SKIN_LEN = 3'd4;

  typedef enum logic [1:0] {
    J_NONE   = 2'd0,
    J_PREFIX = 2'd1,
    J_FULL   = 2'd2
  } judge_t;

  typedef logic [JOB_BYTES-1:0][7:0] win_t;

  // One queued item's worth of results.
  typedef struct packed {
    win_t       bytes;      // kept bytes, from entry 0
    logic [2:0] cnt;        // number of kept bytes
    logic       last;       // item closed the string
    logic       none_kept;  // string ended with nothing kept
  } job_t;

  // Judge the first n bytes of w against the one modifier that its lead byte selects.
  function automatic judge_t judge(input win_t w, input logic [2:0] n, input logic strip);
    logic [2:0] len;
    logic       ok;
    len = 3'd0;
    ok  = 1'b1;
    if (w[0] == SEL_PAT[0] && strip) begin
      len = SEL_LEN;
    end else if (w[0] == ZWJ_PAT[0]) begin
      len = ZWJ_LEN;
    end else if (w[0] == SKIN_PAT[0]) begin
      len = SKIN_LEN;
    end
    case (len)
      SEL_LEN: begin
        for (int i = 0; i < 3; i++) begin
          if (i < int'(n) && w[i] != SEL_PAT[i]) ok = 1'b0;
        end
      end
      ZWJ_LEN: begin
        for (int i = 0; i < 5; i++) begin
          if (i < int'(n) && w[i] != ZWJ_PAT[i]) ok = 1'b0;
        end
        if (n == ZWJ_LEN && w[5] != ZWJ_FEMALE && w[5] != ZWJ_MALE) ok = 1'b0;
      end
      SKIN_LEN: begin
        for (int i = 0; i < 3; i++) begin
          if (i < int'(n) && w[i] != SKIN_PAT[i]) ok = 1'b0;
        end
        if (n == SKIN_LEN && (w[3] < SKIN_LO || w[3] > SKIN_HI)) ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase
    if (n == 3'd0 || n > len || !ok) begin
      return J_NONE;
    end
    return (n == len) ? J_FULL : J_PREFIX;
  endfunction

endpackage

[rtl/utf8_emoji_modifier_stripper.sv]
// Top level of the UTF-8 emoji modifier stripper.
// Depends on ems_pkg, ems_front, ems_queue and ems_back.

// The block filters a UTF-8 string given one byte per input transfer and drops the
// variation selector EF B8 8F (only while strip_selectors is 1), the ZWJ plus female or
// male sign sequences E2 80 8D E2 99 80/82 and the skin tones F0 9F 8F BB..BF. Matching is
// greedy and first-match at each position; up to five bytes of a possible modifier wait
// in a window until they are matched or broken. Every kept byte leaves as one result
// transfer. An input with in_end_of_string set flushes the window; its last result has
// out_last_of_string set, and if the item kept nothing it is a single result with
// out_out_valid low. out_nothing_kept on that final result says no byte of the string
// was kept, so the caller should keep the original. The front part judges all suffixes
// of the window at once, so an input transfer can be taken every clock while the queue has
// room; the result side gives one result per clock unless out_ready stalls it, and a queue
// of QUEUE_DEPTH jobs between the two lets the input run ahead while the output drains or
// is stalled. An item with no byte that ends nothing produces no result.
// strip_selectors resets to 1 and is written through the cfg port, which is always ready;
// write it only while no results are outstanding.
module utf8_emoji_modifier_stripper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_strip_selectors,
  // Input byte channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_byte_present,
  input  logic       in_end_of_string,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic       out_last_of_string,
  output logic       out_nothing_kept
);

  logic          push_valid;
  ems_pkg::job_t push_job;
  logic          q_full;
  logic          head_valid;
  ems_pkg::job_t head_job;
  logic          pop;

  // The register can always take a write.
  assign cfg_ready = 1'b1;

  // A transfer is taken whenever the queue has room for the job it might create.
  assign in_ready = !q_full;

  ems_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_strip_selectors (cfg_strip_selectors),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_byte_present     (in_byte_present),
    .in_end_of_string    (in_end_of_string),
    .push_valid          (push_valid),
    .push_job            (push_job)
  );

  ems_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ems_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (head_valid),
    .head_job           (head_job),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_out_byte       (out_out_byte),
    .out_out_valid      (out_out_valid),
    .out_last_of_string (out_last_of_string),
    .out_nothing_kept   (out_nothing_kept)
  );

`ifndef SYNTH
  // A result without a kept byte only ever closes a string.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_last_of_string)
    else $error("empty result that does not close the string");
  // The nothing-kept flag appears only on a closing result that carries no byte.
  a_nk_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nothing_kept |-> out_last_of_string && !out_out_valid)
    else $error("nothing_kept on a result that is not an empty closing one");
  // Bytes absent from the kept stream read as zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_valid |-> out_out_byte == 8'h00)
    else $error("empty result carries a nonzero byte");
`endif

endmodule

[rtl/ems_front.sv]
// Front part of the emoji modifier stripper: holds the pending window, judges it per item
// and builds one job of kept bytes. Depends on ems_pkg.
module ems_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic            cfg_strip_selectors,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [7:0]      in_data_byte,
  input  logic            in_byte_present,
  input  logic            in_end_of_string,
  output logic            push_valid,
  output ems_pkg::job_t   push_job
);

  logic                                strip_r;
  logic [ems_pkg::WIN_MAX-1:0][7:0]    pend_r, pend_nxt;
  logic [2:0]                          pcnt_r, pcnt_nxt;
  logic                                kept_any_r, kept_any_nxt;

  ems_pkg::win_t                       win, shifted;
  logic [2:0]                          n, s, d, cnt;
  ems_pkg::judge_t [ems_pkg::JOB_BYTES-1:0] j;
  ems_pkg::judge_t                     j_s;
  logic                                keep, acc;

  always_comb begin
    for (int i = 0; i < ems_pkg::WIN_MAX; i++) begin
      win[i] = (3'(i) < pcnt_r) ? pend_r[i] : in_data_byte;
    end
    win[ems_pkg::JOB_BYTES-1] = in_data_byte;
    n = pcnt_r + {2'b00, in_byte_present};
  end

  // Every suffix of the window is judged in parallel.
  always_comb begin
    for (int k = 0; k < ems_pkg::JOB_BYTES; k++) begin
      j[k] = ems_pkg::judge(ems_pkg::win_t'(win >> (8 * k)),
                            (3'(k) < n) ? (n - 3'(k)) : 3'd0, strip_r);
    end
  end

  // s: first suffix that is a prefix or match, d: first full match.
  always_comb begin
    s   = n;
    d   = n;
    j_s = ems_pkg::J_NONE;
    for (int k = ems_pkg::JOB_BYTES - 1; k >= 0; k--) begin
      if (3'(k) < n && j[k] != ems_pkg::J_NONE) begin
        s   = 3'(k);
        j_s = j[k];
      end
      if (3'(k) < n && j[k] == ems_pkg::J_FULL) d = 3'(k);
    end
  end

  always_comb begin
    acc     = in_valid && in_ready;
    shifted = win >> ({3'b000, s} * 6'd8);
    keep    = !in_end_of_string && (s < n) && (j_s == ems_pkg::J_PREFIX);
    cnt     = in_end_of_string ? d : s;
    for (int i = 0; i < ems_pkg::WIN_MAX; i++) begin
      pend_nxt[i] = shifted[i];
    end
    pcnt_nxt     = keep ? (n - s) : 3'd0;
    kept_any_nxt = in_end_of_string ? 1'b0 : (kept_any_r || cnt != 3'd0);

    push_valid         = acc && (cnt != 3'd0 || in_end_of_string);
    push_job.bytes     = win;
    push_job.cnt       = cnt;
    push_job.last      = in_end_of_string;
    push_job.none_kept = !(kept_any_r || cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_r    <= 1'b1;
      pcnt_r     <= 3'd0;
      kept_any_r <= 1'b0;
    end else begin
      if (cfg_valid) strip_r <= cfg_strip_selectors;
      if (acc) begin
        pcnt_r     <= pcnt_nxt;
        kept_any_r <= kept_any_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && keep) pend_r <= pend_nxt;
  end

`ifndef SYNTH
  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= 3'(ems_pkg::WIN_MAX))
    else $error("pending window longer than its storage");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_end_of_string |=> pcnt_r == 3'd0 && !kept_any_r)
    else $error("window not cleared after end of string");
  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_end_of_string |-> push_valid)
    else $error("end of string produced no job");
`endif

endmodule

[rtl/ems_queue.sv]
// Short job queue between the front and back parts of the emoji modifier stripper.
// Depends on ems_pkg for the job type.
module ems_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  ems_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output ems_pkg::job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ems_pkg::job_t     mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  always_comb begin
    full       = (count_r == CW'(DEPTH));
    head_valid = (count_r != '0);
    head_job   = mem_r[rd_ptr_r];
    do_push    = push_valid && !full;
    do_pop     = pop && head_valid;
    count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_push_lost: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !full)
    else $error("job pushed into a full queue");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from an empty queue");
`endif

endmodule

[rtl/ems_back.sv]
// Back part of the emoji modifier stripper: walks the head job one result per cycle, while
// the output is not stalled, into an output register. Depends on ems_pkg.
module ems_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  ems_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_out_byte,
  output logic          out_out_valid,
  output logic          out_last_of_string,
  output logic          out_nothing_kept
);

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] nres;
  logic       last_piece, load;
  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bvalid_r, last_r, nk_r;

  always_comb begin
    nres       = (head_job.cnt == 3'd0) ? 3'd1 : head_job.cnt;
    last_piece = (idx_r + 3'd1 >= nres);
    load       = head_valid && (!valid_r || out_ready);
    pop        = load && last_piece;
    idx_nxt    = last_piece ? 3'd0 : idx_r + 3'd1;
    byte_nxt   = (head_job.cnt == 3'd0) ? 8'h00 : head_job.bytes[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r   <= idx_nxt;
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= byte_nxt;
      bvalid_r <= (head_job.cnt != 3'd0);
      last_r   <= last_piece && head_job.last;
      nk_r     <= last_piece && head_job.last && head_job.none_kept;
    end
  end

  assign out_valid          = valid_r;
  assign out_out_byte       = byte_r;
  assign out_out_valid      = bvalid_r;
  assign out_last_of_string = last_r;
  assign out_nothing_kept   = nk_r;

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r < nres)
    else $error("result index past the end of the job");
  a_pop_resets: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 3'd0)
    else $error("index not rewound after a job");
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");
`endif

endmodule
